// ----- rtl/dwca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_pkg: shared definitions for the consumption average block
// Field widths, register indexes and reset values, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dwca_pkg;

  localparam int SPEED_W  = 15;
  localparam int POWER_W  = 19;
  localparam int AVG_W    = 20;
  localparam int WIN_W    = 26;
  localparam int MAXE_W   = 14;
  localparam int SUMD_W   = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  localparam int HISTORY_DEPTH_DEF = 16384;

  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTR  = 2'd3;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 15'd1000;
  localparam logic [WIN_W-1:0]   WINDOW_RST    = 26'd36360000;
  localparam logic [MAXE_W-1:0]  MAX_ENTR_RST  = 14'd10000;

  typedef struct packed {
    logic push;      // write the new entry and add it to the sums
    logic trim_rd;   // read the oldest entry
    logic pop;       // remove the oldest entry from the sums
    logic mult;      // clamp the energy sum and form energy * 1000
    logic div_step;  // one quotient bit
    logic finish;    // load the result and apply the entry limit
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic need_pop;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/dwca_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_in_if: tick channel
// Valid/ready channel carrying one speed and power sample.
// ----------------------------------------------------------------------------
interface dwca_in_if;
  logic                                valid;
  logic                                ready;
  logic [dwca_pkg::SPEED_W-1:0]        speed;
  logic signed [dwca_pkg::POWER_W-1:0] power;

  modport source (output valid, output speed, output power, input ready);
  modport sink   (input valid, input speed, input power, output ready);
endinterface
`default_nettype wire

// ----- rtl/dwca_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_out_if: result channel
// Valid/ready channel carrying the window average and the clear flag.
// ----------------------------------------------------------------------------
interface dwca_out_if;
  logic                       valid;
  logic                       ready;
  logic [dwca_pkg::AVG_W-1:0] avg_consumption;
  logic                       history_reset;

  modport source (output valid, output avg_consumption, output history_reset,
                  input ready);
  modport sink   (input valid, input avg_consumption, input history_reset,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/dwca_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dwca_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dwca_pkg::CFG_IDX_W-1:0]  idx;
  logic [dwca_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/dwca_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_ctrl: sequencing state machine
// Accepts a tick, walks the trim loop, runs the multiply and the divider, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module dwca_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dwca_pkg::sts_t sts,
  output dwca_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_TRIM_CHK = 6'b000010,
    ST_TRIM_POP = 6'b000100,
    ST_MULT     = 6'b001000,
    ST_DIV      = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // A tick taken while disabled is dropped without touching the state.
        if (in_valid && sts.enable) begin
          cmd.push  = 1'b1;
          state_nxt = ST_TRIM_CHK;
        end
      end
      ST_TRIM_CHK: begin
        if (sts.need_pop) begin
          cmd.trim_rd = 1'b1;
          state_nxt   = ST_TRIM_POP;
        end else begin
          state_nxt = ST_MULT;
        end
      end
      ST_TRIM_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_TRIM_CHK;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/dwca_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwca_dp: datapath
// Configuration registers, entry FIFO memory, running sums, the shift-add
// multiply by 1000, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module dwca_dp #(
  parameter int HISTORY_DEPTH = dwca_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dwca_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [dwca_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [dwca_pkg::SPEED_W-1:0]        in_speed,
  input  wire logic signed [dwca_pkg::POWER_W-1:0] in_power,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dwca_pkg::AVG_W-1:0]               out_avg,
  output logic                                     out_hist,
  input  wire dwca_pkg::cmd_t                      cmd,
  output dwca_pkg::sts_t                           sts
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = CNT_W + 1;
  localparam int SE_W   = ADDR_W + dwca_pkg::POWER_W + 2;
  localparam int P_W    = SE_W - 1 + 10;
  localparam int DCNT_W = $clog2(P_W);
  localparam int CMP_W  = (CNT_W > dwca_pkg::MAXE_W) ? CNT_W : dwca_pkg::MAXE_W;
  localparam int SD_W   = dwca_pkg::SUMD_W;

  // Configuration registers
  logic                          enable_r;
  logic [dwca_pkg::SPEED_W-1:0]  min_speed_r;
  logic [dwca_pkg::WIN_W-1:0]    window_r;
  logic [dwca_pkg::MAXE_W-1:0]   max_entr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      min_speed_r <= dwca_pkg::MIN_SPEED_RST;
      window_r    <= dwca_pkg::WINDOW_RST;
      max_entr_r  <= dwca_pkg::MAX_ENTR_RST;
    end else if (cfg_valid) begin
      case (cfg_idx)
        dwca_pkg::CFG_ENABLE:    enable_r    <= cfg_data[0];
        dwca_pkg::CFG_MIN_SPEED: min_speed_r <= cfg_data[dwca_pkg::SPEED_W-1:0];
        dwca_pkg::CFG_WINDOW:    window_r    <= cfg_data[dwca_pkg::WIN_W-1:0];
        dwca_pkg::CFG_MAX_ENTR:  max_entr_r  <= cfg_data[dwca_pkg::MAXE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Entry memory
  logic [dwca_pkg::SPEED_W-1:0]        mem_dist [HISTORY_DEPTH];
  logic signed [dwca_pkg::POWER_W-1:0] mem_enrg [HISTORY_DEPTH];
  logic [dwca_pkg::SPEED_W-1:0]        rd_dist_r;
  logic signed [dwca_pkg::POWER_W-1:0] rd_enrg_r;

  // Control state of the FIFO and sums
  logic [ADDR_W-1:0]       head_r;
  logic [CNT_W-1:0]        count_r;
  logic [SD_W-1:0]         sum_d_r;
  logic signed [SE_W-1:0]  sum_e_r;

  logic [SLOT_W-1:0]                   slot_sum;
  logic [SLOT_W-1:0]                   slot_wrap;
  logic [ADDR_W-1:0]                   slot;
  logic signed [dwca_pkg::POWER_W-1:0] energy;
  logic [SD_W-1:0]                     pop_d;
  logic [ADDR_W-1:0]                   head_inc;
  logic [CMP_W-1:0]                    limit;
  logic                                over_limit;

  always_comb begin
    slot_sum  = SLOT_W'(head_r) + SLOT_W'(count_r);
    slot_wrap = (slot_sum >= SLOT_W'(HISTORY_DEPTH)) ? slot_sum - SLOT_W'(HISTORY_DEPTH)
                                                     : slot_sum;
    slot      = slot_wrap[ADDR_W-1:0];
    energy    = (in_speed >= min_speed_r) ? in_power : '0;
    pop_d     = (SD_W'(rd_dist_r) <= sum_d_r) ? SD_W'(rd_dist_r) : sum_d_r;
    head_inc  = (head_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
    limit     = (CMP_W'(max_entr_r) > CMP_W'(HISTORY_DEPTH - 1)) ? CMP_W'(HISTORY_DEPTH - 1)
                                                                 : CMP_W'(max_entr_r);
    over_limit = CMP_W'(count_r) > limit;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (in_speed != '0)) begin
      mem_dist[slot] <= in_speed;
      mem_enrg[slot] <= energy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim_rd) begin
      rd_dist_r <= mem_dist[head_r];
      rd_enrg_r <= mem_enrg[head_r];
    end
  end

  // Multiply and divide
  logic [P_W-1:0]    dvd_r;
  logic [SD_W-1:0]   rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [SE_W-1:0]   sum_e_clamp;
  logic [P_W-1:0]    mag;
  logic [P_W-1:0]    prod;
  logic [SD_W:0]     shifted;
  logic [SD_W+1:0]   diff;
  logic              ge;
  logic [dwca_pkg::AVG_W-1:0] avg;

  always_comb begin
    sum_e_clamp = sum_e_r[SE_W-1] ? '0 : sum_e_r;
    mag         = P_W'(sum_e_clamp[SE_W-2:0]);
    // x * 1000 = x * 1024 - x * 16 - x * 8
    prod        = (mag << 10) - (mag << 4) - (mag << 3);
    shifted     = {rem_r, dvd_r[P_W-1]};
    diff        = {1'b0, shifted} - {2'b00, sum_d_r};
    ge          = !diff[SD_W+1];
    if (sum_d_r == '0) begin
      avg = '0;
    end else if (|dvd_r[P_W-1:dwca_pkg::AVG_W]) begin
      avg = dwca_pkg::AVG_MAX;
    end else begin
      avg = dvd_r[dwca_pkg::AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      dvd_r  <= prod;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[P_W-2:0], ge};
      rem_r  <= ge ? diff[SD_W-1:0] : shifted[SD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.mult) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      sum_d_r <= '0;
      sum_e_r <= '0;
    end else if (cmd.push) begin
      if (in_speed != '0) begin
        count_r <= count_r + 1'b1;
        sum_d_r <= sum_d_r + SD_W'(in_speed);
        sum_e_r <= sum_e_r + SE_W'(energy);
      end
    end else if (cmd.pop) begin
      head_r  <= head_inc;
      count_r <= count_r - 1'b1;
      sum_d_r <= sum_d_r - pop_d;
      sum_e_r <= sum_e_r - SE_W'(rd_enrg_r);
    end else if (cmd.mult) begin
      sum_e_r <= sum_e_clamp;
    end else if (cmd.finish && over_limit) begin
      head_r  <= '0;
      count_r <= '0;
      sum_d_r <= '0;
      sum_e_r <= '0;
    end
  end

  // Output register
  logic                       out_valid_r;
  logic [dwca_pkg::AVG_W-1:0] out_avg_r;
  logic                       out_hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_avg_r  <= avg;
      out_hist_r <= over_limit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_hist  = out_hist_r;

  always_comb begin
    sts.enable   = enable_r;
    sts.need_pop = (sum_d_r > SD_W'(window_r)) && (count_r != '0);
    sts.div_last = (dcnt_r == DCNT_W'(P_W - 1));
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// ----- rtl/distance_window_consumption_average_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// distance_window_consumption_average_top: distance-weighted consumption average
// Keeps a FIFO of per-tick distance and energy and reports the energy per
// distance over a sliding distance window, in 0.1 Wh/km.
// ----------------------------------------------------------------------------
// Each tick transaction carries one second of speed and battery power. While
// enabled, every tick produces exactly one result transaction; while disabled,
// ticks are taken and dropped with no effect. After a tick is accepted, the
// old entries that have left the window are removed (usually zero or one),
// each with a read state and a pop state on the single read port of the entry
// memory. Then the multiply and the restoring divider run; the divider
// produces one quotient bit per cycle, and the number of quotient bits
// follows the energy sum width and so the HISTORY_DEPTH parameter. The result
// is then loaded into the output register, and the next tick can be accepted
// in the cycle after that. The last step also waits for as long as an earlier
// result is still held, untaken, in the output register. The block works on
// one tick at a time; the output register lets a new tick be accepted while
// the previous result is still waiting to be taken. The entry memory needs no
// clearing after reset: only entries that have been written are ever read.
// Configuration writes are always accepted and should be issued only while no
// tick is in flight.
// ----------------------------------------------------------------------------
module distance_window_consumption_average_top #(
  parameter int HISTORY_DEPTH = dwca_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dwca_in_if.sink     in_ch,
  dwca_out_if.source  out_ch,
  dwca_cfg_if.sink    cfg_ch
);

  dwca_pkg::cmd_t cmd;
  dwca_pkg::sts_t sts;
  logic           in_ready;

  // The controller owns the input handshake; the datapath owns the sums, the
  // entry memory, the arithmetic and the output register.
  dwca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  dwca_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_idx   (cfg_ch.idx),
    .cfg_data  (cfg_ch.data),
    .in_speed  (in_ch.speed),
    .in_power  (in_ch.power),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_avg   (out_ch.avg_consumption),
    .out_hist  (out_ch.history_reset),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A finished result always shows up on the output channel in the next cycle.
  a_finish_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("result not presented after finish");

  // A tick taken while disabled leaves the block idle and ready.
  a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !sts.enable) |=> in_ch.ready)
    else $error("disabled tick started processing");

  // No new tick is taken while the divider or trim loop is busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.pop || cmd.mult) |-> !in_ch.ready)
    else $error("tick accepted while busy");

  // The result is never loaded over a waiting, untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");

endmodule
`default_nettype wire
